// File: design/spe_pkg.sv
// Shared types, constants and elaboration-time tables for the sinusoidal
// position encoder. No dependencies.
package spe_pkg;

    localparam int CFG_BITS      = 13;
    localparam int SEQ_POS_BITS  = 16;
    localparam int PAIR_BITS     = 11;
    localparam int DIVIDEND_BITS = 32;
    localparam int EXP_BITS      = 20;
    localparam int FRAC_STEPS    = 16;
    localparam int INT_BITS      = EXP_BITS - FRAC_STEPS;
    localparam int FREQ_BITS     = 33;
    localparam int ROOT_BITS     = 32;
    localparam int ANGLE_BITS    = 35;
    localparam int Z_BITS        = 36;
    localparam int XY_BITS       = 34;
    localparam int ATAN_BITS     = 34;
    localparam int CORDIC_STEPS  = 32;

    localparam logic [CFG_BITS-1:0] RESET_MODEL_WIDTH = 13'd512;
    localparam logic [31:0] LOG2_BASE_Q16 = 32'd870824;
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
    localparam logic [63:0] QUARTER_PI_Q32 = 64'd3373259426;
    localparam logic signed [Z_BITS-1:0] TWO_PI_Z  = 36'sd26986075409;
    localparam logic signed [Z_BITS-1:0] PI_Z      = 36'sd13493037705;
    localparam logic signed [Z_BITS-1:0] HALF_PI_Z = 36'sd6746518852;
    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic valid;
        logic oor;
    } item_ctl_t;

    typedef struct packed {
        logic valid;
        logic oor;
        logic neg;
    } rot_ctl_t;

    typedef logic [ROOT_BITS-1:0] root_tab_t [FRAC_STEPS];
    typedef logic [ATAN_BITS-1:0] atan_tab_t [CORDIC_STEPS];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int n;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (n = 0; n < 32; n++) begin
            if (b > v) b = b >> 2;
        end
        for (n = 0; n < 32; n++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Restoring division, used only while building constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        int b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry j holds 2^(-2^-(j+1)) in Q0.32.
    function automatic root_tab_t make_root_tab();
        root_tab_t t;
        logic [63:0] s;
        int j;
        s = isqrt64(64'h8000_0000_0000_0000);
        t[0] = s[ROOT_BITS-1:0];
        for (j = 1; j < FRAC_STEPS; j++) begin
            s = isqrt64({t[j-1], 32'h0});
            t[j] = s[ROOT_BITS-1:0];
        end
        return t;
    endfunction

    // Entry i holds atan(2^-i) in Q.32 from a truncated Taylor series.
    function automatic atan_tab_t make_atan_tab();
        atan_tab_t t;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] odd;
        logic [63:0] amt;
        logic [63:0] rnd;
        int i;
        int n;
        t[0] = QUARTER_PI_Q32[ATAN_BITS-1:0];
        for (i = 1; i < CORDIC_STEPS; i++) begin
            s = '0;
            for (n = 0; n < 31; n++) begin
                odd = 64'(2 * n + 1);
                amt = odd * 64'(i);
                if (amt <= 64'd60) begin
                    term = udiv64(64'd1 << (64'd60 - amt), odd);
                    if ((n % 2) == 0) s = s + term;
                    else s = s - term;
                end
            end
            rnd = (s + (64'd1 << 27)) >> 28;
            t[i] = rnd[ATAN_BITS-1:0];
        end
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = make_root_tab();
    localparam atan_tab_t ATAN_TAB = make_atan_tab();

endpackage

// File: design/sinusoidal_position_encoder_top.sv
// Sinusoidal position encoder: one transaction per cycle, fully pipelined.
// The result strobe done follows each accepted transaction through the
// 20-stage divider, the 16 root multiplies, the four-stage modulo reduction
// and the 32 CORDIC stages.
// Throughput is one transaction per cycle; busy stays low in operation.
// Reset clears all pipeline valids and loads a model width of 512.
module sinusoidal_position_encoder_top #(
    parameter int POSITION_BITS   = 16,
    parameter int MAX_MODEL_WIDTH = 4096,
    parameter int OUTPUT_BITS     = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [spe_pkg::SEQ_POS_BITS-1:0] seq_pos,
    input  logic [spe_pkg::PAIR_BITS-1:0]    pair_num,
    input  logic                             cfg_write,
    input  logic [spe_pkg::CFG_BITS-1:0]     cfg_data,
    output logic                             done,
    output logic signed [OUTPUT_BITS-1:0]    sine_part,
    output logic signed [OUTPUT_BITS-1:0]    cosine_part,
    output logic                             pair_out_of_range
);
    import spe_pkg::*;

    localparam int WIDTH_BITS = $clog2(MAX_MODEL_WIDTH + 1);

    item_ctl_t                q_ctl;
    logic [POSITION_BITS-1:0] q_pos;
    logic [DIVIDEND_BITS-1:0] q_dividend;
    logic [WIDTH_BITS-1:0]    q_width;
    item_ctl_t                f_ctl;
    logic [POSITION_BITS-1:0] f_pos;
    logic [FREQ_BITS-1:0]     f_freq;
    rot_ctl_t                 a_ctl;
    logic signed [Z_BITS-1:0] a_z;

    spe_front #(
        .POSITION_BITS   (POSITION_BITS),
        .MAX_MODEL_WIDTH (MAX_MODEL_WIDTH),
        .WIDTH_BITS      (WIDTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .seq_pos    (seq_pos),
        .pair_num   (pair_num),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .q_ctl      (q_ctl),
        .q_pos      (q_pos),
        .q_dividend (q_dividend),
        .q_width    (q_width)
    );

    spe_freq #(
        .POSITION_BITS (POSITION_BITS),
        .WIDTH_BITS    (WIDTH_BITS)
    ) u_freq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ctl      (q_ctl),
        .in_pos      (q_pos),
        .in_dividend (q_dividend),
        .in_width    (q_width),
        .out_ctl     (f_ctl),
        .out_pos     (f_pos),
        .out_freq    (f_freq)
    );

    spe_angle #(
        .POSITION_BITS (POSITION_BITS)
    ) u_angle (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (f_ctl),
        .in_pos  (f_pos),
        .in_freq (f_freq),
        .out_ctl (a_ctl),
        .out_z   (a_z)
    );

    spe_cordic #(
        .OUTPUT_BITS (OUTPUT_BITS)
    ) u_cordic (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_ctl            (a_ctl),
        .in_z              (a_z),
        .done              (done),
        .sine_part         (sine_part),
        .cosine_part       (cosine_part),
        .pair_out_of_range (pair_out_of_range)
    );

endmodule

// File: design/spe_front.sv
// Front end: configuration register, accept and range check of each
// transaction, and a short queue toward the arithmetic back end. Uses spe_pkg.
module spe_front #(
    parameter int POSITION_BITS   = 16,
    parameter int MAX_MODEL_WIDTH = 4096,
    parameter int WIDTH_BITS      = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [spe_pkg::SEQ_POS_BITS-1:0]   seq_pos,
    input  logic [spe_pkg::PAIR_BITS-1:0]      pair_num,
    input  logic                               cfg_write,
    input  logic [spe_pkg::CFG_BITS-1:0]       cfg_data,
    output spe_pkg::item_ctl_t                 q_ctl,
    output logic [POSITION_BITS-1:0]           q_pos,
    output logic [spe_pkg::DIVIDEND_BITS-1:0]  q_dividend,
    output logic [WIDTH_BITS-1:0]              q_width
);
    import spe_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_BITS  = 1 + POSITION_BITS + DIVIDEND_BITS + WIDTH_BITS;

    logic [CFG_BITS-1:0]   model_width_reg;
    logic [ENTRY_BITS-1:0] queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    logic                     push;
    logic                     pop;
    logic [31:0]              width_clamped;
    logic                     oor;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [ENTRY_BITS-1:0]    entry;
    logic [ENTRY_BITS-1:0]    head;

    assign busy = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop  = (count_reg != '0);

    // A width above the supported maximum acts as the maximum.
    assign width_clamped = (32'(model_width_reg) > 32'(MAX_MODEL_WIDTH)) ?
                           32'(MAX_MODEL_WIDTH) : 32'(model_width_reg);
    assign oor      = (32'(pair_num) >= (width_clamped >> 1));
    assign dividend = DIVIDEND_BITS'({pair_num, 1'b0}) * LOG2_BASE_Q16;
    assign entry    = {oor, POSITION_BITS'(seq_pos), dividend,
                       width_clamped[WIDTH_BITS-1:0]};

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_width_reg <= RESET_MODEL_WIDTH;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (cfg_write) model_width_reg <= cfg_data;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) queue_reg[wr_ptr_reg] <= entry;
    end

    assign head       = queue_reg[rd_ptr_reg];
    assign q_ctl.valid = pop;
    assign q_ctl.oor   = head[ENTRY_BITS-1];
    assign q_pos       = head[ENTRY_BITS-2 -: POSITION_BITS];
    assign q_dividend  = head[WIDTH_BITS +: DIVIDEND_BITS];
    assign q_width     = head[WIDTH_BITS-1:0];

endmodule

// File: design/spe_freq.sv
// Frequency pipeline: exponent 2k*log2(10000)/W by a one-bit-per-stage
// divider, then 2^-e from a chain of root multiplies and a final shift. Uses spe_pkg.
module spe_freq #(
    parameter int POSITION_BITS = 16,
    parameter int WIDTH_BITS    = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spe_pkg::item_ctl_t                in_ctl,
    input  logic [POSITION_BITS-1:0]          in_pos,
    input  logic [spe_pkg::DIVIDEND_BITS-1:0] in_dividend,
    input  logic [WIDTH_BITS-1:0]             in_width,
    output spe_pkg::item_ctl_t                out_ctl,
    output logic [POSITION_BITS-1:0]          out_pos,
    output logic [spe_pkg::FREQ_BITS-1:0]     out_freq
);
    import spe_pkg::*;

    // Divider stages
    item_ctl_t                div_ctl_reg  [EXP_BITS];
    logic [WIDTH_BITS-1:0]    div_rem_reg  [EXP_BITS];
    logic [EXP_BITS-1:0]      div_quo_reg  [EXP_BITS];
    logic [EXP_BITS-1:0]      div_num_reg  [EXP_BITS];
    logic [WIDTH_BITS-1:0]    div_w_reg    [EXP_BITS];
    logic [POSITION_BITS-1:0] div_pos_reg  [EXP_BITS];
    item_ctl_t                div_ctl_next [EXP_BITS];
    logic [WIDTH_BITS-1:0]    div_rem_next [EXP_BITS];
    logic [EXP_BITS-1:0]      div_quo_next [EXP_BITS];
    logic [EXP_BITS-1:0]      div_num_next [EXP_BITS];
    logic [WIDTH_BITS-1:0]    div_w_next   [EXP_BITS];
    logic [POSITION_BITS-1:0] div_pos_next [EXP_BITS];

    // Root multiply stages
    item_ctl_t                rt_ctl_reg  [FRAC_STEPS];
    logic [FREQ_BITS-1:0]     rt_m_reg    [FRAC_STEPS];
    logic [EXP_BITS-1:0]      rt_e_reg    [FRAC_STEPS];
    logic [POSITION_BITS-1:0] rt_pos_reg  [FRAC_STEPS];
    item_ctl_t                rt_ctl_next [FRAC_STEPS];
    logic [FREQ_BITS-1:0]     rt_m_next   [FRAC_STEPS];
    logic [EXP_BITS-1:0]      rt_e_next   [FRAC_STEPS];
    logic [POSITION_BITS-1:0] rt_pos_next [FRAC_STEPS];

    // Output shift stage
    item_ctl_t                sh_ctl_reg;
    logic [FREQ_BITS-1:0]     sh_freq_reg;
    logic [POSITION_BITS-1:0] sh_pos_reg;

    logic [DIVIDEND_BITS-1:0] dividend_top;

    assign dividend_top = in_dividend >> EXP_BITS;

    // The quotient is below 2^20, so the top dividend bits start below W.
    always_comb
    begin
        for (int s = 0; s < EXP_BITS; s++)
        begin
            logic [WIDTH_BITS:0]      trial;
            item_ctl_t                c;
            logic [WIDTH_BITS-1:0]    r;
            logic [EXP_BITS-1:0]      q;
            logic [EXP_BITS-1:0]      n;
            logic [WIDTH_BITS-1:0]    w;
            logic [POSITION_BITS-1:0] p;
            if (s == 0)
            begin
                c = in_ctl;
                r = dividend_top[WIDTH_BITS-1:0];
                q = '0;
                n = in_dividend[EXP_BITS-1:0];
                w = in_width;
                p = in_pos;
            end
            else
            begin
                c = div_ctl_reg[s-1];
                r = div_rem_reg[s-1];
                q = div_quo_reg[s-1];
                n = div_num_reg[s-1];
                w = div_w_reg[s-1];
                p = div_pos_reg[s-1];
            end
            trial = {r, n[EXP_BITS-1-s]};
            if (trial >= {1'b0, w})
            begin
                div_rem_next[s] = WIDTH_BITS'(trial - {1'b0, w});
                div_quo_next[s] = {q[EXP_BITS-2:0], 1'b1};
            end
            else
            begin
                div_rem_next[s] = trial[WIDTH_BITS-1:0];
                div_quo_next[s] = {q[EXP_BITS-2:0], 1'b0};
            end
            div_ctl_next[s] = c;
            div_num_next[s] = n;
            div_w_next[s]   = w;
            div_pos_next[s] = p;
        end
    end

    // One multiply per stage; fraction bits are taken from the top down.
    always_comb
    begin
        for (int j = 0; j < FRAC_STEPS; j++)
        begin
            logic [FREQ_BITS+ROOT_BITS-1:0] prod;
            item_ctl_t                      c;
            logic [FREQ_BITS-1:0]           m;
            logic [EXP_BITS-1:0]            e;
            logic [POSITION_BITS-1:0]       p;
            if (j == 0)
            begin
                c = div_ctl_reg[EXP_BITS-1];
                m = FREQ_BITS'(1) << ROOT_BITS;
                e = div_quo_reg[EXP_BITS-1];
                p = div_pos_reg[EXP_BITS-1];
            end
            else
            begin
                c = rt_ctl_reg[j-1];
                m = rt_m_reg[j-1];
                e = rt_e_reg[j-1];
                p = rt_pos_reg[j-1];
            end
            prod = (FREQ_BITS+ROOT_BITS)'(m) * (FREQ_BITS+ROOT_BITS)'(ROOT_TAB[j]);
            if (e[FRAC_STEPS-1-j]) rt_m_next[j] = prod[ROOT_BITS +: FREQ_BITS];
            else rt_m_next[j] = m;
            rt_ctl_next[j] = c;
            rt_e_next[j]   = e;
            rt_pos_next[j] = p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < EXP_BITS; s++) div_ctl_reg[s] <= '0;
            for (int j = 0; j < FRAC_STEPS; j++) rt_ctl_reg[j] <= '0;
            sh_ctl_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < EXP_BITS; s++) div_ctl_reg[s] <= div_ctl_next[s];
            for (int j = 0; j < FRAC_STEPS; j++) rt_ctl_reg[j] <= rt_ctl_next[j];
            sh_ctl_reg <= rt_ctl_reg[FRAC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < EXP_BITS; s++)
        begin
            div_rem_reg[s] <= div_rem_next[s];
            div_quo_reg[s] <= div_quo_next[s];
            div_num_reg[s] <= div_num_next[s];
            div_w_reg[s]   <= div_w_next[s];
            div_pos_reg[s] <= div_pos_next[s];
        end
        for (int j = 0; j < FRAC_STEPS; j++)
        begin
            rt_m_reg[j]   <= rt_m_next[j];
            rt_e_reg[j]   <= rt_e_next[j];
            rt_pos_reg[j] <= rt_pos_next[j];
        end
        sh_freq_reg <= rt_m_reg[FRAC_STEPS-1] >> rt_e_reg[FRAC_STEPS-1][EXP_BITS-1 -: INT_BITS];
        sh_pos_reg  <= rt_pos_reg[FRAC_STEPS-1];
    end

    assign out_ctl  = sh_ctl_reg;
    assign out_pos  = sh_pos_reg;
    assign out_freq = sh_freq_reg;

endmodule

// File: design/spe_angle.sv
// Angle pipeline: position times frequency in two partial products, reduction
// modulo 2*pi by reciprocal multiplication with one correction step, and
// folding into [-pi/2, pi/2]. Uses spe_pkg.
module spe_angle #(
    parameter int POSITION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spe_pkg::item_ctl_t               in_ctl,
    input  logic [POSITION_BITS-1:0]         in_pos,
    input  logic [spe_pkg::FREQ_BITS-1:0]    in_freq,
    output spe_pkg::rot_ctl_t                out_ctl,
    output logic signed [spe_pkg::Z_BITS-1:0] out_z
);
    import spe_pkg::*;

    localparam int LO_BITS   = 16;
    localparam int HI_BITS   = FREQ_BITS - LO_BITS;
    localparam int PROD_BITS = POSITION_BITS + FREQ_BITS;
    localparam int SCL_BITS  = 30;
    localparam int EST_BITS  = PROD_BITS - SCL_BITS;
    localparam int RCP_SHIFT = POSITION_BITS + 8;
    localparam int RCP_BITS  = POSITION_BITS + 5;
    localparam int Q_BITS    = POSITION_BITS;
    localparam logic [63:0] RCP_FULL = (64'd1 << (RCP_SHIFT + SCL_BITS)) / TWO_PI_Q32;
    localparam logic [RCP_BITS-1:0] RCP = RCP_FULL[RCP_BITS-1:0];

    item_ctl_t                         mu_ctl_reg;
    logic [POSITION_BITS+HI_BITS-1:0]  mu_hi_reg;
    logic [POSITION_BITS+LO_BITS-1:0]  mu_lo_reg;
    item_ctl_t                         sm_ctl_reg;
    logic [PROD_BITS-1:0]              sm_prod_reg;
    item_ctl_t                         qe_ctl_reg;
    logic [PROD_BITS-1:0]              qe_prod_reg;
    logic [Q_BITS-1:0]                 qe_q_reg;
    item_ctl_t                         qm_ctl_reg;
    logic [PROD_BITS-1:0]              qm_prod_reg;
    logic [PROD_BITS-1:0]              qm_sub_reg;
    item_ctl_t                         rs_ctl_reg;
    logic [PROD_BITS-1:0]              rs_val_reg;
    item_ctl_t                         rc_ctl_reg;
    logic [ANGLE_BITS-1:0]             rc_val_reg;
    rot_ctl_t                          fo_ctl_reg;
    logic signed [Z_BITS-1:0]          fo_z_reg;

    logic [EST_BITS+RCP_BITS-1:0] est_prod;
    logic [PROD_BITS-1:0]         rs_fix;
    logic signed [Z_BITS-1:0]     z_wrap;
    logic signed [Z_BITS-1:0]     z_fold;
    logic                         z_neg;

    // The quotient estimate is low by at most one, so a single
    // compare and subtract finishes the reduction.
    assign est_prod = (EST_BITS+RCP_BITS)'(sm_prod_reg[PROD_BITS-1:SCL_BITS]) *
                      (EST_BITS+RCP_BITS)'(RCP);
    assign rs_fix   = (rs_val_reg >= PROD_BITS'(TWO_PI_Q32)) ?
                      rs_val_reg - PROD_BITS'(TWO_PI_Q32) : rs_val_reg;

    always_comb
    begin
        z_wrap = $signed({1'b0, rc_val_reg});
        if (z_wrap > PI_Z) z_wrap = z_wrap - TWO_PI_Z;
        z_fold = z_wrap;
        z_neg  = 1'b0;
        if (z_wrap > HALF_PI_Z)
        begin
            z_fold = z_wrap - PI_Z;
            z_neg  = 1'b1;
        end
        else if (z_wrap < -HALF_PI_Z)
        begin
            z_fold = z_wrap + PI_Z;
            z_neg  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_ctl_reg <= '0;
            sm_ctl_reg <= '0;
            qe_ctl_reg <= '0;
            qm_ctl_reg <= '0;
            rs_ctl_reg <= '0;
            rc_ctl_reg <= '0;
            fo_ctl_reg <= '0;
        end
        else
        begin
            mu_ctl_reg       <= in_ctl;
            sm_ctl_reg       <= mu_ctl_reg;
            qe_ctl_reg       <= sm_ctl_reg;
            qm_ctl_reg       <= qe_ctl_reg;
            rs_ctl_reg       <= qm_ctl_reg;
            rc_ctl_reg       <= rs_ctl_reg;
            fo_ctl_reg.valid <= rc_ctl_reg.valid;
            fo_ctl_reg.oor   <= rc_ctl_reg.oor;
            fo_ctl_reg.neg   <= z_neg;
        end
    end

    always_ff @(posedge clk)
    begin
        mu_hi_reg   <= (POSITION_BITS+HI_BITS)'(in_pos) *
                       (POSITION_BITS+HI_BITS)'(in_freq[FREQ_BITS-1:LO_BITS]);
        mu_lo_reg   <= (POSITION_BITS+LO_BITS)'(in_pos) *
                       (POSITION_BITS+LO_BITS)'(in_freq[LO_BITS-1:0]);
        sm_prod_reg <= PROD_BITS'({mu_hi_reg, {LO_BITS{1'b0}}}) + PROD_BITS'(mu_lo_reg);
        qe_prod_reg <= sm_prod_reg;
        qe_q_reg    <= est_prod[RCP_SHIFT +: Q_BITS];
        qm_prod_reg <= qe_prod_reg;
        qm_sub_reg  <= PROD_BITS'(qe_q_reg) * PROD_BITS'(TWO_PI_Q32);
        rs_val_reg  <= qm_prod_reg - qm_sub_reg;
        rc_val_reg  <= rs_fix[ANGLE_BITS-1:0];
        fo_z_reg    <= z_fold;
    end

    assign out_ctl = fo_ctl_reg;
    assign out_z   = fo_z_reg;

endmodule

// File: design/spe_cordic.sv
// Rotation CORDIC with one micro-rotation per stage, then sign fix, rounding
// and saturation to the output format. Uses spe_pkg.
module spe_cordic #(
    parameter int OUTPUT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spe_pkg::rot_ctl_t                 in_ctl,
    input  logic signed [spe_pkg::Z_BITS-1:0] in_z,
    output logic                              done,
    output logic signed [OUTPUT_BITS-1:0]     sine_part,
    output logic signed [OUTPUT_BITS-1:0]     cosine_part,
    output logic                              pair_out_of_range
);
    import spe_pkg::*;

    localparam int FRAC     = OUTPUT_BITS - 1;
    localparam int RSH      = (FRAC <= 30) ? 30 - FRAC : 0;
    localparam int LSH      = (FRAC > 30) ? FRAC - 30 : 0;
    localparam logic signed [Z_BITS-1:0] RND =
        (RSH > 0) ? (36'sd1 <<< ((RSH > 0) ? RSH - 1 : 0)) : 36'sd0;
    localparam logic signed [Z_BITS-1:0] LIM = 36'sd1 <<< FRAC;

    rot_ctl_t                  cr_ctl_reg [CORDIC_STEPS];
    logic signed [XY_BITS-1:0] cr_x_reg   [CORDIC_STEPS];
    logic signed [XY_BITS-1:0] cr_y_reg   [CORDIC_STEPS];
    logic signed [Z_BITS-1:0]  cr_z_reg   [CORDIC_STEPS];
    logic signed [XY_BITS-1:0] cr_x_next  [CORDIC_STEPS];
    logic signed [XY_BITS-1:0] cr_y_next  [CORDIC_STEPS];
    logic signed [Z_BITS-1:0]  cr_z_next  [CORDIC_STEPS];

    logic                          done_reg;
    logic signed [OUTPUT_BITS-1:0] sine_reg;
    logic signed [OUTPUT_BITS-1:0] cosine_reg;
    logic                          oor_reg;
    logic signed [OUTPUT_BITS-1:0] sine_next;
    logic signed [OUTPUT_BITS-1:0] cosine_next;

    function automatic logic signed [OUTPUT_BITS-1:0] to_out(
        input logic signed [XY_BITS-1:0] v_in
    );
        logic signed [Z_BITS-1:0] v;
        v = Z_BITS'(v_in);
        v = ((v + RND) >>> RSH) <<< LSH;
        if (v >= LIM) v = LIM - 36'sd1;
        if (v < -LIM) v = -LIM;
        return v[OUTPUT_BITS-1:0];
    endfunction

    // Shifts are arithmetic, so they round toward minus infinity.
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            logic signed [XY_BITS-1:0] x;
            logic signed [XY_BITS-1:0] y;
            logic signed [Z_BITS-1:0]  z;
            logic signed [Z_BITS-1:0]  a;
            if (i == 0)
            begin
                x = CORDIC_GAIN_Q30;
                y = '0;
                z = in_z;
            end
            else
            begin
                x = cr_x_reg[i-1];
                y = cr_y_reg[i-1];
                z = cr_z_reg[i-1];
            end
            a = $signed(Z_BITS'(ATAN_TAB[i]));
            if (z >= 0)
            begin
                cr_x_next[i] = x - (y >>> i);
                cr_y_next[i] = y + (x >>> i);
                cr_z_next[i] = z - a;
            end
            else
            begin
                cr_x_next[i] = x + (y >>> i);
                cr_y_next[i] = y - (x >>> i);
                cr_z_next[i] = z + a;
            end
        end
    end

    always_comb
    begin
        logic signed [XY_BITS-1:0] xs;
        logic signed [XY_BITS-1:0] ys;
        xs = cr_x_reg[CORDIC_STEPS-1];
        ys = cr_y_reg[CORDIC_STEPS-1];
        if (cr_ctl_reg[CORDIC_STEPS-1].neg)
        begin
            xs = -xs;
            ys = -ys;
        end
        sine_next   = to_out(ys);
        cosine_next = to_out(xs);
        if (cr_ctl_reg[CORDIC_STEPS-1].oor)
        begin
            sine_next   = '0;
            cosine_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++) cr_ctl_reg[i] <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cr_ctl_reg[0] <= in_ctl;
            for (int i = 1; i < CORDIC_STEPS; i++) cr_ctl_reg[i] <= cr_ctl_reg[i-1];
            done_reg <= cr_ctl_reg[CORDIC_STEPS-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            cr_x_reg[i] <= cr_x_next[i];
            cr_y_reg[i] <= cr_y_next[i];
            cr_z_reg[i] <= cr_z_next[i];
        end
        sine_reg   <= sine_next;
        cosine_reg <= cosine_next;
        oor_reg    <= cr_ctl_reg[CORDIC_STEPS-1].oor;
    end

    assign done              = done_reg;
    assign sine_part         = sine_reg;
    assign cosine_part       = cosine_reg;
    assign pair_out_of_range = oor_reg;

endmodule
